// ===== src/simplified_aes_block_cipher_assert.svh =====
// Assertion macros shared by the cipher block.
// Every macro samples on the rising edge of clk and is held off during rst.
`ifndef SIMPLIFIED_AES_BLOCK_CIPHER_ASSERT_SVH
`define SIMPLIFIED_AES_BLOCK_CIPHER_ASSERT_SVH

// Implication that must hold in the same cycle.
`define SAES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence must hold in the following cycle.
`define SAES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/saes_pkg.sv =====
`timescale 1ns / 1ps

package saes_pkg;

  localparam int BlockWidth = 16;
  localparam int NibWidth   = 4;

  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  localparam logic [7:0] Rcon1  = 8'h80;
  localparam logic [7:0] Rcon2  = 8'h30;
  localparam logic [4:0] GfPoly = 5'h13;

  localparam logic [3:0] FwdBox [16] = '{
    4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
    4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
  };

  localparam logic [3:0] InvBox [16] = '{
    4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
    4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
  };

  typedef struct packed {
    logic [BlockWidth-1:0] k0;
    logic [BlockWidth-1:0] k1;
    logic [BlockWidth-1:0] k2;
  } round_keys_t;

  typedef struct packed {
    logic                  op;
    logic [BlockWidth-1:0] blk;
  } stage_t;

  localparam int StageWidth = $bits(stage_t);

  // Product of two nibbles in GF(2^4) modulo x^4 + x + 1.
  function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] acc;
    logic [3:0] x;
    acc = 4'h0;
    x   = a;
    for (int k = 0; k < NibWidth; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      x = {x[2:0], 1'b0} ^ (x[3] ? GfPoly[3:0] : 4'h0);
    end
    return acc;
  endfunction

  function automatic logic [15:0] sub_word(input logic [15:0] s);
    return {FwdBox[s[15:12]], FwdBox[s[11:8]], FwdBox[s[7:4]], FwdBox[s[3:0]]};
  endfunction

  function automatic logic [15:0] inv_sub_word(input logic [15:0] s);
    return {InvBox[s[15:12]], InvBox[s[11:8]], InvBox[s[7:4]], InvBox[s[3:0]]};
  endfunction

  // Swaps the second nibble of each column in the bottom row.
  function automatic logic [15:0] shift_row(input logic [15:0] s);
    return {s[15:12], s[3:0], s[7:4], s[11:8]};
  endfunction

  // Column-wise multiply by the matrix [[p, q], [q, p]].
  function automatic logic [15:0] mix_word(input logic [15:0] s, input logic [3:0] p,
                                           input logic [3:0] q);
    return {gf_mul(p, s[15:12]) ^ gf_mul(q, s[11:8]),
            gf_mul(q, s[15:12]) ^ gf_mul(p, s[11:8]),
            gf_mul(p, s[7:4])   ^ gf_mul(q, s[3:0]),
            gf_mul(q, s[7:4])   ^ gf_mul(p, s[3:0])};
  endfunction

  // SubNib applied after RotNib on one key byte.
  function automatic logic [7:0] sub_rot_byte(input logic [7:0] b);
    return {FwdBox[b[3:0]], FwdBox[b[7:4]]};
  endfunction

endpackage

// ===== src/saes_key_sched.sv =====
`timescale 1ns / 1ps

module saes_key_sched (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [15:0]             cfg_wdata,
  output saes_pkg::round_keys_t   rkeys
);
  import saes_pkg::*;

  logic [BlockWidth-1:0] cipher_key;
  logic [7:0]            w0, w1, w2, w3, w4, w5;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
    end else if (cfg_we) begin
      cipher_key <= cfg_wdata;
    end
  end

  // The key must only be written while the block is idle, which the block
  // does not enforce; the schedule is derived straight from the key register.
  always_comb begin
    w0 = cipher_key[15:8];
    w1 = cipher_key[7:0];
    w2 = w0 ^ Rcon1 ^ sub_rot_byte(w1);
    w3 = w2 ^ w1;
    w4 = w2 ^ Rcon2 ^ sub_rot_byte(w3);
    w5 = w4 ^ w3;
    rkeys.k0 = {w0, w1};
    rkeys.k1 = {w2, w3};
    rkeys.k2 = {w4, w5};
  end

endmodule

// ===== src/saes_stage.sv =====
`timescale 1ns / 1ps

module saes_stage #(
  parameter int WIDTH = saes_pkg::StageWidth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  input  logic [WIDTH-1:0] up_data,
  output logic             up_ready,
  output logic             down_valid,
  output logic [WIDTH-1:0] down_data,
  input  logic             down_ready
);

  logic             valid;
  logic [WIDTH-1:0] data;

  // The stage loads whenever it is empty or its content leaves this cycle.
  assign up_ready   = !valid || down_ready;
  assign down_valid = valid;
  assign down_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= up_data;
    end
  end

endmodule

// ===== src/simplified_aes_block_cipher.sv =====
`timescale 1ns / 1ps

// Simplified AES on 16-bit blocks with a 16-bit key. Each transaction on the
// input channel carries one block and an operation (op 0 encrypts, op 1
// decrypts) and yields exactly one result block, in order. The datapath is a
// three-stage pipeline: a new transaction may be accepted on every clock
// cycle while the output is not stalled. A transaction accepted into the
// stage 1 register moves on through the stage 2 and stage 3 registers, the
// last of which is the output register, and is taken from there when the
// output is not stalled. A stall on the output
// backs up stage by stage; empty stages still accept, so nothing is lost or
// repeated. The key is written through cfg_we/cfg_wdata and resets to zero;
// it must only be written while no transaction is in flight.
// Stage 1 does the first key addition and the first nibble substitution and
// row swap, stage 2 the column mixing and middle key addition, stage 3 the
// final substitution, row swap and key addition, all mirrored for decryption.
module simplified_aes_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [15:0] data_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] result_block
);
  import saes_pkg::*;

  round_keys_t rkeys;
  stage_t      s0_in, s1_in, s1_q, s2_in, s2_q, s3_in, s3_q;
  logic        s1_valid, s2_valid;
  logic        s1_ready, s2_ready, s3_ready;

  saes_key_sched u_key_sched (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rkeys     (rkeys)
  );

  assign s0_in.op  = op;
  assign s0_in.blk = data_block;

  // Stage 1: encrypt adds K0, substitutes and swaps rows; decrypt adds K2,
  // swaps rows, inverse-substitutes and adds K1.
  always_comb begin
    s1_in.op = s0_in.op;
    if (s0_in.op == OpDecrypt) begin
      s1_in.blk = inv_sub_word(shift_row(s0_in.blk ^ rkeys.k2)) ^ rkeys.k1;
    end else begin
      s1_in.blk = shift_row(sub_word(s0_in.blk ^ rkeys.k0));
    end
  end

  saes_stage #(.WIDTH(StageWidth)) u_stage1 (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (in_valid),
    .up_data    (s1_in),
    .up_ready   (s1_ready),
    .down_valid (s1_valid),
    .down_data  (s1_q),
    .down_ready (s2_ready)
  );

  // Stage 2: encrypt mixes columns with [[1,4],[4,1]] and adds K1; decrypt
  // mixes columns with the inverse matrix [[9,2],[2,9]].
  always_comb begin
    s2_in.op = s1_q.op;
    if (s1_q.op == OpDecrypt) begin
      s2_in.blk = mix_word(s1_q.blk, 4'h9, 4'h2);
    end else begin
      s2_in.blk = mix_word(s1_q.blk, 4'h1, 4'h4) ^ rkeys.k1;
    end
  end

  saes_stage #(.WIDTH(StageWidth)) u_stage2 (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (s1_valid),
    .up_data    (s2_in),
    .up_ready   (s2_ready),
    .down_valid (s2_valid),
    .down_data  (s2_q),
    .down_ready (s3_ready)
  );

  // Stage 3: encrypt substitutes, swaps rows and adds K2; decrypt swaps rows,
  // inverse-substitutes and adds K0.
  always_comb begin
    s3_in.op = s2_q.op;
    if (s2_q.op == OpDecrypt) begin
      s3_in.blk = inv_sub_word(shift_row(s2_q.blk)) ^ rkeys.k0;
    end else begin
      s3_in.blk = shift_row(sub_word(s2_q.blk)) ^ rkeys.k2;
    end
  end

  saes_stage #(.WIDTH(StageWidth)) u_stage3 (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (s2_valid),
    .up_data    (s3_in),
    .up_ready   (s3_ready),
    .down_valid (out_valid),
    .down_data  (s3_q),
    .down_ready (!out_stall)
  );

  assign in_stall     = !s1_ready;
  assign result_block = s3_q.blk;

`include "simplified_aes_block_cipher_assert.svh"

  // An unstalled output lets every stage advance, so the input must be open.
  `SAES_ASSERT_NOW(a_flow_open, !out_stall, !in_stall, "input stalled with output open")
  // A transaction leaving stage 1 into an open stage 2 must show up there.
  `SAES_ASSERT_NEXT(a_s1_to_s2, s1_valid && s2_ready, s2_valid, "stage 2 lost a transaction")
  // A transaction leaving stage 2 into an open stage 3 must reach the output.
  `SAES_ASSERT_NEXT(a_s2_to_out, s2_valid && s3_ready, out_valid, "output lost a transaction")

endmodule

// ===== bench/simplified_aes_block_cipher_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the 16-bit simplified AES cipher. A driver pushes block
// transactions from a queue of pending items, a monitor checks every result
// in order against an independent prediction, and a sequencer walks the run
// through several keys and several patterns of input gaps and output stalls.
module simplified_aes_block_cipher_tb;
  import saes_pkg::*;

  // The block has three pipeline stages. This bounds how long the pipeline
  // can take to empty once the last result has been seen.
  localparam int PipeDepth = 3;

  // Coefficients of the forward and inverse column mixing matrices.
  localparam logic [3:0] MixDiag    = 4'h1;
  localparam logic [3:0] MixOff     = 4'h4;
  localparam logic [3:0] InvMixDiag = 4'h9;
  localparam logic [3:0] InvMixOff  = 4'h2;

  localparam int RandomPhases   = 8;
  localparam int ItemsPerPhase  = 116;
  localparam int MaxReportLines = 50;

  typedef struct packed {
    logic        op;
    logic [15:0] blk;
  } block_txn_t;

  typedef struct packed {
    logic [15:0] k0;
    logic [15:0] k1;
    logic [15:0] k2;
  } key_schedule_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OpEncrypt;
  logic [15:0] data_block = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] result_block;

  // Transactions waiting to be driven, and result blocks still owed by the
  // block, oldest first.
  block_txn_t    pending_items[$];
  logic [15:0]   expected_blocks[$];
  block_txn_t    next_txn;

  // Key schedule that matches the key currently held in the block. The
  // block resets its key to zero, so the schedule starts from that key.
  key_schedule_t round_keys;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;

  simplified_aes_block_cipher dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .data_block  (data_block),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_block(result_block)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Prediction of the cipher, built up from the nibble operations.
  // ---------------------------------------------------------------------

  // Product of two nibbles in GF(2^4), reduced by x^4 + x + 1.
  function automatic logic [3:0] gf16_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] prod;
    logic [3:0] shifted;
    int         i;
    prod    = 4'h0;
    shifted = a;
    for (i = 0; i < 4; i++) begin
      if (b[i]) begin
        prod = prod ^ shifted;
      end
      shifted = shifted[3] ? ({shifted[2:0], 1'b0} ^ GfPoly[3:0]) : {shifted[2:0], 1'b0};
    end
    return prod;
  endfunction

  // Runs every nibble of the state through the forward or inverse S-box.
  function automatic logic [15:0] nibble_subst(input logic [15:0] w, input logic inverse);
    logic [15:0] r;
    logic [3:0]  nib;
    int          i;
    r = 16'h0000;
    for (i = 0; i < 4; i++) begin
      nib          = w[4*i +: 4];
      r[4*i +: 4]  = inverse ? InvBox[nib] : FwdBox[nib];
    end
    return r;
  endfunction

  // The row swap exchanges the low nibbles of the two columns; it is its
  // own inverse.
  function automatic logic [15:0] swap_low_row(input logic [15:0] w);
    logic [15:0] r;
    r        = w;
    r[11:8]  = w[3:0];
    r[3:0]   = w[11:8];
    return r;
  endfunction

  // Each column (high nibble on top) is multiplied by [[d, o], [o, d]].
  function automatic logic [15:0] mix_columns(input logic [15:0] w, input logic [3:0] d,
                                              input logic [3:0] o);
    logic [15:0] r;
    int          c;
    r = 16'h0000;
    for (c = 0; c < 2; c++) begin
      r[8*c+4 +: 4] = gf16_mul(d, w[8*c+4 +: 4]) ^ gf16_mul(o, w[8*c +: 4]);
      r[8*c   +: 4] = gf16_mul(o, w[8*c+4 +: 4]) ^ gf16_mul(d, w[8*c +: 4]);
    end
    return r;
  endfunction

  // Key byte after the nibble rotation and the forward S-box.
  function automatic logic [7:0] rotated_subst(input logic [7:0] b);
    return {FwdBox[b[3:0]], FwdBox[b[7:4]]};
  endfunction

  function automatic key_schedule_t expand_cipher_key(input logic [15:0] key);
    key_schedule_t ks;
    logic [7:0]    w2;
    logic [7:0]    w3;
    logic [7:0]    w4;
    w2    = key[15:8] ^ Rcon1 ^ rotated_subst(key[7:0]);
    w3    = w2 ^ key[7:0];
    w4    = w2 ^ Rcon2 ^ rotated_subst(w3);
    ks.k0 = key;
    ks.k1 = {w2, w3};
    ks.k2 = {w4, w4 ^ w3};
    return ks;
  endfunction

  // The block expected for one transaction under the current key schedule.
  function automatic logic [15:0] cipher_block(input logic mode, input logic [15:0] blk);
    logic [15:0] s;
    if (mode == OpDecrypt) begin
      s = blk ^ round_keys.k2;
      s = nibble_subst(swap_low_row(s), 1'b1) ^ round_keys.k1;
      s = mix_columns(s, InvMixDiag, InvMixOff);
      s = nibble_subst(swap_low_row(s), 1'b1) ^ round_keys.k0;
    end else begin
      s = nibble_subst(blk ^ round_keys.k0, 1'b0);
      s = mix_columns(swap_low_row(s), MixDiag, MixOff) ^ round_keys.k1;
      s = swap_low_row(nibble_subst(s, 1'b0)) ^ round_keys.k2;
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Driver. A transaction is taken at an edge where in_valid is high and
  // in_stall is low; the expectation is recorded at that same edge, from the
  // payload that was being held. A new payload is only presented when the
  // channel is free, so a stalled payload never changes.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_blocks.insert(expected_blocks.size(), cipher_block(op, data_block));
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_txn   = pending_items.pop_front();
          in_valid   <= 1'b1;
          op         <= next_txn.op;
          data_block <= next_txn.blk;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor. Every accepted result transaction is matched against the
  // oldest outstanding expectation. The output stall is redrawn each cycle.
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatch_count < MaxReportLines) begin
      $display("[%0t] %s: result_block got %h, expected %h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    logic [15:0] want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch("unexpected result", result_block, 16'hxxxx);
        end else begin
          want = expected_blocks.pop_front();
          if (result_block !== want) begin
            report_mismatch("wrong result", result_block, want);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencing of the run.
  // ---------------------------------------------------------------------
  task automatic push_item(input logic mode, input logic [15:0] blk);
    block_txn_t t;
    t.op  = mode;
    t.blk = blk;
    pending_items.insert(pending_items.size(), t);
  endtask

  // Holds the sender off until every transaction has been driven and every
  // result has come back, then lets the pipeline settle. The key may only be
  // changed after this.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_blocks.size() != 0) begin
      @(negedge clk);
    end
    repeat (PipeDepth + 1) @(negedge clk);
  endtask

  // The register takes the value at the edge after cfg_we is raised. The
  // predictor switches keys at once, which is safe because nothing is in
  // flight while the key changes.
  task automatic program_key(input logic [15:0] key);
    @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= key;
    round_keys = expand_cipher_key(key);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // A burst of random transactions under one key and one gap/stall pattern.
  // Some are encrypt-then-decrypt pairs so the round trip back to the
  // plaintext is exercised, and some use the all-zero and all-one blocks.
  task automatic random_phase(input logic [15:0] key, input int unsigned send_pct,
                              input int unsigned stall_pct, input int count);
    logic [15:0] plain;
    int          n;
    int unsigned pick;
    program_key(key);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    n = 0;
    while (n < count) begin
      pick  = $urandom_range(9);
      plain = 16'($urandom_range(16'hFFFF));
      if (pick == 0) begin
        push_item(OpEncrypt, plain);
        push_item(OpDecrypt, cipher_block(OpEncrypt, plain));
        n += 2;
      end else if (pick == 1) begin
        push_item(1'($urandom_range(1)), $urandom_range(1) ? 16'hFFFF : 16'h0000);
        n++;
      end else begin
        push_item(1'($urandom_range(1)), plain);
        n++;
      end
    end
    wait_drained();
  endtask

  initial begin
    logic [15:0]   phase_keys [RandomPhases];
    int unsigned   send_pcts  [4];
    int unsigned   stall_pcts [4];
    int            p;
    send_pcts  = '{0, 82, 0, 7};
    stall_pcts = '{0, 0, 82, 7};
    round_keys = expand_cipher_key(16'h0000);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the key left by reset: extreme blocks in both
    // directions, and single set bits at either end of the block.
    push_item(OpEncrypt, 16'h0000);
    push_item(OpDecrypt, 16'h0000);
    push_item(OpEncrypt, 16'hFFFF);
    push_item(OpDecrypt, 16'hFFFF);
    push_item(OpEncrypt, 16'h0001);
    push_item(OpDecrypt, 16'h8000);
    push_item(OpEncrypt, 16'hA5A5);
    push_item(OpDecrypt, 16'h5A5A);
    wait_drained();

    // Directed part under a textbook key: the known plaintext, its
    // ciphertext decrypted back, and nibble patterns that touch every S-box
    // entry in both directions.
    program_key(16'h4AF5);
    push_item(OpEncrypt, 16'hD728);
    push_item(OpDecrypt, cipher_block(OpEncrypt, 16'hD728));
    push_item(OpEncrypt, 16'h0123);
    push_item(OpEncrypt, 16'h4567);
    push_item(OpEncrypt, 16'h89AB);
    push_item(OpEncrypt, 16'hCDEF);
    push_item(OpDecrypt, 16'h0123);
    push_item(OpDecrypt, 16'h4567);
    push_item(OpDecrypt, 16'h89AB);
    push_item(OpDecrypt, 16'hCDEF);
    push_item(OpEncrypt, 16'hFFFF);
    push_item(OpDecrypt, 16'h0000);
    wait_drained();

    // Random part. The first two keys are the extremes; the rest are random.
    phase_keys[0] = 16'hFFFF;
    phase_keys[1] = 16'h0000;
    for (p = 2; p < RandomPhases; p++) begin
      phase_keys[p] = 16'($urandom_range(16'hFFFF));
    end
    for (p = 0; p < RandomPhases; p++) begin
      random_phase(phase_keys[p], send_pcts[p % 4], stall_pcts[p % 4], ItemsPerPhase);
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/saes_pkg.sv
src/saes_key_sched.sv
src/saes_stage.sv
src/simplified_aes_block_cipher.sv
bench/simplified_aes_block_cipher_tb.sv
